FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the profile checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge, quiet while reset is asserted.
`define ASSERT_AT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent this edge, consequent on the following edge.
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
  `ASSERT_AT(lbl, clk, rst_n, (pre) |=> (post), msg)

`endif

FILE: rtl/tpp_pkg.sv
// ----------------------------------------------------------------------------
// tpp_pkg
// Constants, codes and interface types of the trapezoidal position profile.
// ----------------------------------------------------------------------------
package tpp_pkg;

  localparam int FRAC_BITS = 16;

  localparam logic [31:0] ONE_Q       = 32'(64'd1 << FRAC_BITS);
  localparam logic [31:0] DT_Q        = 32'(((64'd2 << FRAC_BITS) + 64'd500) / 64'd1000);
  localparam logic [31:0] MIN_ACCEL_Q = 32'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);
  localparam logic [63:0] PROD_CAP    = 64'd1 << 62;

  localparam logic [30:0] ANGLE_LIMIT_RST = 31'(64'd720 << FRAC_BITS);
  localparam logic [31:0] VEL_LIMIT_RST   = 32'(64'd1000 << FRAC_BITS);
  localparam logic [31:0] ACC_LIMIT_RST   = 32'(64'd1000 << FRAC_BITS);

  localparam int CFG_IDX_W = 3;

  // Move direction, two's complement
  localparam logic [1:0] DIR_NONE = 2'b00;
  localparam logic [1:0] DIR_POS  = 2'b01;
  localparam logic [1:0] DIR_NEG  = 2'b11;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARGET_ANGLE    = 3'd0,
    CFG_TARGET_VELOCITY = 3'd1,
    CFG_TARGET_ACCEL    = 3'd2,
    CFG_ANGLE_LIMIT     = 3'd3,
    CFG_VELOCITY_LIMIT  = 3'd4,
    CFG_ACCEL_LIMIT     = 3'd5
  } cfg_idx_e;

  typedef enum logic [2:0] {
    PH_WAIT   = 3'd0,
    PH_ACCEL  = 3'd1,
    PH_CRUISE = 3'd2,
    PH_DECEL  = 3'd3,
    PH_HOLD   = 3'd4
  } phase_e;

  typedef enum logic [4:0] {
    OP_NOP,
    OP_LATCH,
    OP_CAPTURE,
    OP_MUL_VV,
    OP_DIV_Q,
    OP_STORE_Q,
    OP_DIV_X,
    OP_SQRT,
    OP_MUL_PEAK,
    OP_STORE_PEAK,
    OP_DIV_RAMP,
    OP_STORE_RAMP,
    OP_STORE_CRUISE,
    OP_MUL_TT,
    OP_MUL_P1,
    OP_MUL_P2,
    OP_MUL_LIN,
    OP_COMMIT
  } dp_op_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EVAL,
    S_VV,
    S_DQ_GO,
    S_DQ_WAIT,
    S_BRANCH,
    S_DX_WAIT,
    S_SQ_WAIT,
    S_PEAK,
    S_DR_WAIT,
    S_DC_WAIT,
    S_P1,
    S_P2,
    S_LIN,
    S_OUT
  } ctrl_state_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic rising;
    logic cur_wait;
    logic tri_move;
    logic div_done;
    logic sqrt_done;
  } dp_status_t;

endpackage

FILE: rtl/trapezoidal_position_profile.sv
// Tick in motion or hold: t*t, the parabolic products and the linear term go through the four
//   shared multiplies, then the result is committed once the output is free and the next transfer taken.
// Tick in wait: evaluation goes straight to the output commit.
// Tick on the enable's rising edge: the plan runs through the bit-serial divider and, for a
//   triangle, the 32-step root before the result is committed.
// Reset clears configuration to defaults, the phase to wait and the enable history.
// ----------------------------------------------------------------------------
// trapezoidal_position_profile
// Trapezoidal (or triangular) position profile generator, one result per tick.
// ----------------------------------------------------------------------------
module trapezoidal_position_profile (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // tick input
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           move_enable_i,
  input  logic signed [31:0]             measured_position_i,
  // result output
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic signed [31:0]             angle_command_o,
  output logic [2:0]                     profile_phase_o,
  // configuration writes
  input  logic                           cfg_we_i,
  input  logic [tpp_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [31:0]                    cfg_data_i
);

  // The controller steps through one tick at a time; the datapath holds the
  // plan, the segment origin and the phase time between ticks. The output
  // register is separate, so a new tick is taken while a result waits.
  tpp_pkg::dp_cmd_t    dp_cmd;
  tpp_pkg::dp_status_t dp_status;

  tpp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (dp_status),
    .cmd_o       (dp_cmd)
  );

  // Plan on the rising edge: clamp, divide v*v by a, choose triangle or
  // trapezoid, then derive ramp, cruise and peak speed. Otherwise form t*t,
  // the parabolic term and the linear term (none in wait), and advance the segment.
  tpp_dp u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (dp_cmd),
    .status_o            (dp_status),
    .move_enable_i       (move_enable_i),
    .measured_position_i (measured_position_i),
    .cfg_we_i            (cfg_we_i),
    .cfg_idx_i           (cfg_idx_i),
    .cfg_data_i          (cfg_data_i),
    .angle_command_o     (angle_command_o),
    .profile_phase_o     (profile_phase_o)
  );

endmodule

FILE: rtl/tpp_div.sv
// ----------------------------------------------------------------------------
// tpp_div
// Restoring divider, 64-bit dividend by 32-bit divisor, one bit per cycle.
// ----------------------------------------------------------------------------
module tpp_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        done_o,
  output logic [63:0] quot_o,
  output logic [31:0] rem_o
);

  logic        busy_q, done_q;
  logic [5:0]  cnt_q;
  logic [63:0] quot_q;
  logic [31:0] rem_q, dvs_q;
  logic [32:0] rem_sh, rem_sub;
  logic        fits;

  always_comb begin
    rem_sh  = {rem_q, quot_q[63]};
    rem_sub = rem_sh - {1'b0, dvs_q};
    fits    = (rem_sh >= {1'b0, dvs_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == '1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Dividend shifts out of the top of the quotient register as bits come in
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= dividend_i;
      rem_q  <= '0;
      dvs_q  <= divisor_i;
    end else if (busy_q) begin
      quot_q <= {quot_q[62:0], fits};
      rem_q  <= fits ? rem_sub[31:0] : rem_sh[31:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

FILE: rtl/tpp_sqrt.sv
// ----------------------------------------------------------------------------
// tpp_sqrt
// Digit-by-digit integer square root of a 64-bit value, one root bit a cycle.
// ----------------------------------------------------------------------------
module tpp_sqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] radicand_i,
  output logic        done_o,
  output logic [31:0] root_o
);

  logic        busy_q, done_q;
  logic [4:0]  cnt_q;
  logic [63:0] rad_q;
  logic [31:0] root_q;
  logic [33:0] rem_q;
  logic [35:0] rem_sh, trial;
  logic        fits;

  always_comb begin
    rem_sh = {rem_q, rad_q[63:62]};
    trial  = {2'b00, root_q, 2'b01};
    fits   = (rem_sh >= trial);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == '1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= radicand_i;
      root_q <= '0;
      rem_q  <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[61:0], 2'b00};
      root_q <= {root_q[30:0], fits};
      rem_q  <= fits ? 34'(rem_sh - trial) : rem_sh[33:0];
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

FILE: rtl/tpp_dp.sv
// ----------------------------------------------------------------------------
// tpp_dp
// Profile datapath: configuration, move plan, shared multiplier, divider and
// root units, command arithmetic and the output register.
// ----------------------------------------------------------------------------
module tpp_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  tpp_pkg::dp_cmd_t               cmd_i,
  output tpp_pkg::dp_status_t            status_o,
  input  logic                           move_enable_i,
  input  logic signed [31:0]             measured_position_i,
  input  logic                           cfg_we_i,
  input  logic [tpp_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [31:0]                    cfg_data_i,
  output logic signed [31:0]             angle_command_o,
  output logic [2:0]                     profile_phase_o
);

  localparam int F = tpp_pkg::FRAC_BITS;

  // configuration
  logic [31:0] tang_q, tvel_q, tacc_q, vlim_q, alim_acc_q;
  logic [30:0] alim_q;

  // control state
  tpp_pkg::phase_e phase_q;
  logic            enable_prev_q;

  // item and plan payload
  logic            en_q;
  logic [31:0]     pos_q, start_q, origin_q, t_q;
  logic [1:0]      dir_q;
  logic [31:0]     ramp_q, cruise_q, peak_q, acc_q, v_q, d_q, q_q;
  logic            tri_q;
  logic [63:0]     prod_q, p1_q, para_q;
  logic [31-F:0]   tth_q;
  logic [31:0]     angle_q;
  tpp_pkg::phase_e phase_out_q;

  // units
  logic        div_start, div_done, sqrt_start, sqrt_done;
  logic [63:0] div_dividend, div_quot;
  logic [31:0] div_divisor, div_rem, sq_root;

  function automatic logic [31:0] sat32(input logic [63:0] v);
    return (|v[63:32]) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  // ---------------- capture and clamp ----------------
  logic signed [32:0] lim_s, ang_s, fin_s;
  logic signed [33:0] diff_s;
  logic [31:0]        vmin, v_cl, amin, a_cl, d_cl;
  logic [1:0]         dir_cl;

  always_comb begin
    lim_s = $signed({2'b00, alim_q});
    ang_s = $signed({tang_q[31], tang_q});
    if (ang_s > lim_s) begin
      fin_s = lim_s;
    end else if (ang_s < -lim_s) begin
      fin_s = -lim_s;
    end else begin
      fin_s = ang_s;
    end
    vmin   = (tvel_q > vlim_q) ? vlim_q : tvel_q;
    v_cl   = (vmin < tpp_pkg::ONE_Q) ? tpp_pkg::ONE_Q : vmin;
    amin   = (tacc_q > alim_acc_q) ? alim_acc_q : tacc_q;
    a_cl   = (amin < tpp_pkg::MIN_ACCEL_Q) ? tpp_pkg::MIN_ACCEL_Q : amin;
    diff_s = $signed({fin_s[32], fin_s}) - $signed({{2{pos_q[31]}}, pos_q});
    d_cl   = diff_s[33] ? 32'(-diff_s) : diff_s[31:0];
    if (diff_s > 0) begin
      dir_cl = tpp_pkg::DIR_POS;
    end else if (diff_s < 0) begin
      dir_cl = tpp_pkg::DIR_NEG;
    end else begin
      dir_cl = tpp_pkg::DIR_NONE;
    end
  end

  // ---------------- shared multiplier ----------------
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;

  always_comb begin
    case (cmd_i.op)
      tpp_pkg::OP_MUL_VV: begin
        mul_a = v_q;
        mul_b = v_q;
      end
      tpp_pkg::OP_MUL_PEAK: begin
        mul_a = sq_root;
        mul_b = acc_q;
      end
      tpp_pkg::OP_MUL_TT: begin
        mul_a = t_q;
        mul_b = t_q;
      end
      tpp_pkg::OP_MUL_P1: begin
        mul_a = prod_q[F+31:F];
        mul_b = acc_q;
      end
      tpp_pkg::OP_MUL_P2: begin
        mul_a = {{F{1'b0}}, tth_q};
        mul_b = acc_q;
      end
      tpp_pkg::OP_MUL_LIN: begin
        mul_a = peak_q;
        mul_b = t_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p = {32'd0, mul_a} * {32'd0, mul_b};
  end

  // ---------------- divider and root operands ----------------
  always_comb begin
    div_start = 1'b1;
    case (cmd_i.op)
      tpp_pkg::OP_DIV_Q: begin
        div_dividend = prod_q;
        div_divisor  = acc_q;
      end
      tpp_pkg::OP_DIV_X: begin
        div_dividend = {32'd0, d_q} << F;
        div_divisor  = acc_q;
      end
      tpp_pkg::OP_DIV_RAMP: begin
        div_dividend = {32'd0, v_q} << F;
        div_divisor  = acc_q;
      end
      tpp_pkg::OP_STORE_RAMP: begin
        div_dividend = {32'd0, d_q - q_q} << F;
        div_divisor  = v_q;
      end
      default: begin
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = acc_q;
      end
    endcase
    sqrt_start = (cmd_i.op == tpp_pkg::OP_SQRT);
  end

  tpp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  tpp_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sqrt_start),
    .radicand_i (div_quot << F),
    .done_o     (sqrt_done),
    .root_o     (sq_root)
  );

  // ---------------- parabolic term ----------------
  logic [95:0] wide, wide_sh;
  logic [63:0] para_d;

  always_comb begin
    wide    = {prod_q, 32'd0} + {32'd0, p1_q};
    wide_sh = wide >> F;
    para_d  = (wide_sh > {32'd0, tpp_pkg::PROD_CAP}) ? (tpp_pkg::PROD_CAP >> 1)
                                                      : (wide_sh[63:0] >> 1);
  end

  // ---------------- command and phase advance ----------------
  tpp_pkg::phase_e    cur;
  logic [63:0]        lin;
  logic signed [65:0] x_s, term_s, sum_s;
  logic [31:0]        cmd, limit, t_inc;
  logic [32:0]        t_sum;
  logic               seg_end;
  tpp_pkg::phase_e    next_ph;

  always_comb begin
    cur = en_q ? phase_q : tpp_pkg::PH_WAIT;
    lin = prod_q >> F;
    case (cur)
      tpp_pkg::PH_ACCEL:  x_s = $signed({2'b00, para_q});
      tpp_pkg::PH_CRUISE: x_s = $signed({2'b00, lin});
      tpp_pkg::PH_DECEL:  x_s = $signed({2'b00, lin}) - $signed({2'b00, para_q});
      default:            x_s = '0;
    endcase
    case (dir_q)
      tpp_pkg::DIR_POS: term_s = x_s;
      tpp_pkg::DIR_NEG: term_s = -x_s;
      default:          term_s = '0;
    endcase
    sum_s = $signed({{34{origin_q[31]}}, origin_q}) + term_s;
    if (!sum_s[65] && (|sum_s[64:31])) begin
      cmd = 32'h7FFF_FFFF;
    end else if (sum_s[65] && !(&sum_s[64:31])) begin
      cmd = 32'h8000_0000;
    end else begin
      cmd = sum_s[31:0];
    end
    case (cur)
      tpp_pkg::PH_ACCEL:  next_ph = tpp_pkg::PH_CRUISE;
      tpp_pkg::PH_CRUISE: next_ph = tpp_pkg::PH_DECEL;
      default:            next_ph = tpp_pkg::PH_HOLD;
    endcase
    limit   = (cur == tpp_pkg::PH_CRUISE) ? cruise_q : ramp_q;
    seg_end = (t_q >= limit);
    t_sum   = {1'b0, t_q} + {1'b0, tpp_pkg::DT_Q};
    t_inc   = t_sum[32] ? 32'hFFFF_FFFF : t_sum[31:0];
  end

  // ---------------- control registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tang_q        <= '0;
      tvel_q        <= tpp_pkg::ONE_Q;
      tacc_q        <= tpp_pkg::ONE_Q;
      alim_q        <= tpp_pkg::ANGLE_LIMIT_RST;
      vlim_q        <= tpp_pkg::VEL_LIMIT_RST;
      alim_acc_q    <= tpp_pkg::ACC_LIMIT_RST;
      phase_q       <= tpp_pkg::PH_WAIT;
      enable_prev_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (tpp_pkg::cfg_idx_e'(cfg_idx_i))
          tpp_pkg::CFG_TARGET_ANGLE:    tang_q     <= cfg_data_i;
          tpp_pkg::CFG_TARGET_VELOCITY: tvel_q     <= cfg_data_i;
          tpp_pkg::CFG_TARGET_ACCEL:    tacc_q     <= cfg_data_i;
          tpp_pkg::CFG_ANGLE_LIMIT:     alim_q     <= cfg_data_i[30:0];
          tpp_pkg::CFG_VELOCITY_LIMIT:  vlim_q     <= cfg_data_i;
          tpp_pkg::CFG_ACCEL_LIMIT:     alim_acc_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.op == tpp_pkg::OP_COMMIT) begin
        enable_prev_q <= en_q;
        case (cur)
          tpp_pkg::PH_ACCEL, tpp_pkg::PH_CRUISE, tpp_pkg::PH_DECEL: begin
            if (seg_end) begin
              phase_q <= next_ph;
            end
          end
          tpp_pkg::PH_HOLD: phase_q <= tpp_pkg::PH_HOLD;
          default:          phase_q <= en_q ? tpp_pkg::PH_ACCEL : tpp_pkg::PH_WAIT;
        endcase
      end
    end
  end

  // ---------------- payload registers ----------------
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      tpp_pkg::OP_LATCH: begin
        en_q  <= move_enable_i;
        pos_q <= measured_position_i;
      end
      tpp_pkg::OP_CAPTURE: begin
        start_q <= pos_q;
        v_q     <= v_cl;
        acc_q   <= a_cl;
        d_q     <= d_cl;
        dir_q   <= dir_cl;
      end
      tpp_pkg::OP_STORE_Q: begin
        tri_q <= ({32'd0, d_q} < div_quot) || (({32'd0, d_q} == div_quot) && (div_rem != '0));
        q_q   <= div_quot[31:0];
      end
      tpp_pkg::OP_STORE_PEAK: begin
        peak_q   <= sat32(prod_q >> F);
        cruise_q <= '0;
      end
      tpp_pkg::OP_STORE_RAMP:   ramp_q <= sat32(div_quot);
      tpp_pkg::OP_STORE_CRUISE: begin
        cruise_q <= sat32(div_quot);
        peak_q   <= v_q;
      end
      tpp_pkg::OP_MUL_P1: tth_q <= prod_q[63:F+32];
      tpp_pkg::OP_MUL_P2: p1_q  <= prod_q;
      tpp_pkg::OP_MUL_LIN: para_q <= para_d;
      tpp_pkg::OP_COMMIT: begin
        phase_out_q <= cur;
        case (cur)
          tpp_pkg::PH_ACCEL, tpp_pkg::PH_CRUISE, tpp_pkg::PH_DECEL: begin
            angle_q <= cmd;
            if (seg_end) begin
              origin_q <= cmd;
              t_q      <= '0;
            end else begin
              t_q <= t_inc;
            end
          end
          tpp_pkg::PH_HOLD: begin
            angle_q <= origin_q;
            t_q     <= '0;
          end
          default: begin
            angle_q  <= pos_q;
            origin_q <= start_q;
            t_q      <= '0;
          end
        endcase
      end
      default: ;
    endcase
    // sqrt root doubles as the ramp time of a triangular move
    if (cmd_i.op == tpp_pkg::OP_MUL_PEAK) begin
      ramp_q <= sq_root;
    end
    if ((cmd_i.op == tpp_pkg::OP_MUL_VV) || (cmd_i.op == tpp_pkg::OP_MUL_PEAK) ||
        (cmd_i.op == tpp_pkg::OP_MUL_TT) || (cmd_i.op == tpp_pkg::OP_MUL_P1) ||
        (cmd_i.op == tpp_pkg::OP_MUL_P2) || (cmd_i.op == tpp_pkg::OP_MUL_LIN)) begin
      prod_q <= mul_p;
    end
  end

  always_comb begin
    status_o.rising    = en_q & ~enable_prev_q;
    status_o.cur_wait  = (cur == tpp_pkg::PH_WAIT);
    status_o.tri_move  = tri_q;
    status_o.div_done  = div_done;
    status_o.sqrt_done = sqrt_done;
  end

  assign angle_command_o = angle_q;
  assign profile_phase_o = phase_out_q;

endmodule

FILE: rtl/tpp_ctrl.sv
// ----------------------------------------------------------------------------
// tpp_ctrl
// Sequencer for one tick: plan on the enable's rising edge, evaluate the
// profile terms otherwise (skipped in wait), then commit the result to the output register.
// ----------------------------------------------------------------------------
module tpp_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  tpp_pkg::dp_status_t status_i,
  output tpp_pkg::dp_cmd_t    cmd_o
);

  tpp_pkg::ctrl_state_e state_q, state_d;
  logic                 out_valid_q, out_valid_d;
  logic                 out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      tpp_pkg::S_IDLE:    if (in_valid_i) state_d = tpp_pkg::S_EVAL;
      tpp_pkg::S_EVAL: begin
        if (status_i.rising) begin
          state_d = tpp_pkg::S_VV;
        end else if (status_i.cur_wait) begin
          state_d = tpp_pkg::S_OUT;
        end else begin
          state_d = tpp_pkg::S_P1;
        end
      end
      tpp_pkg::S_VV:      state_d = tpp_pkg::S_DQ_GO;
      tpp_pkg::S_DQ_GO:   state_d = tpp_pkg::S_DQ_WAIT;
      tpp_pkg::S_DQ_WAIT: if (status_i.div_done) state_d = tpp_pkg::S_BRANCH;
      tpp_pkg::S_BRANCH:  state_d = status_i.tri_move ? tpp_pkg::S_DX_WAIT : tpp_pkg::S_DR_WAIT;
      tpp_pkg::S_DX_WAIT: if (status_i.div_done) state_d = tpp_pkg::S_SQ_WAIT;
      tpp_pkg::S_SQ_WAIT: if (status_i.sqrt_done) state_d = tpp_pkg::S_PEAK;
      tpp_pkg::S_PEAK:    state_d = tpp_pkg::S_OUT;
      tpp_pkg::S_DR_WAIT: if (status_i.div_done) state_d = tpp_pkg::S_DC_WAIT;
      tpp_pkg::S_DC_WAIT: if (status_i.div_done) state_d = tpp_pkg::S_OUT;
      tpp_pkg::S_P1:      state_d = tpp_pkg::S_P2;
      tpp_pkg::S_P2:      state_d = tpp_pkg::S_LIN;
      tpp_pkg::S_LIN:     state_d = tpp_pkg::S_OUT;
      tpp_pkg::S_OUT:     if (out_free) state_d = tpp_pkg::S_IDLE;
      default:            state_d = tpp_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.op    = tpp_pkg::OP_NOP;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      tpp_pkg::S_IDLE:    if (in_valid_i) cmd_o.op = tpp_pkg::OP_LATCH;
      tpp_pkg::S_EVAL: begin
        if (status_i.rising) begin
          cmd_o.op = tpp_pkg::OP_CAPTURE;
        end else if (!status_i.cur_wait) begin
          cmd_o.op = tpp_pkg::OP_MUL_TT;
        end
      end
      tpp_pkg::S_VV:      cmd_o.op = tpp_pkg::OP_MUL_VV;
      tpp_pkg::S_DQ_GO:   cmd_o.op = tpp_pkg::OP_DIV_Q;
      tpp_pkg::S_DQ_WAIT: if (status_i.div_done) cmd_o.op = tpp_pkg::OP_STORE_Q;
      tpp_pkg::S_BRANCH:  cmd_o.op = status_i.tri_move ? tpp_pkg::OP_DIV_X : tpp_pkg::OP_DIV_RAMP;
      tpp_pkg::S_DX_WAIT: if (status_i.div_done) cmd_o.op = tpp_pkg::OP_SQRT;
      tpp_pkg::S_SQ_WAIT: if (status_i.sqrt_done) cmd_o.op = tpp_pkg::OP_MUL_PEAK;
      tpp_pkg::S_PEAK:    cmd_o.op = tpp_pkg::OP_STORE_PEAK;
      tpp_pkg::S_DR_WAIT: if (status_i.div_done) cmd_o.op = tpp_pkg::OP_STORE_RAMP;
      tpp_pkg::S_DC_WAIT: if (status_i.div_done) cmd_o.op = tpp_pkg::OP_STORE_CRUISE;
      tpp_pkg::S_P1:      cmd_o.op = tpp_pkg::OP_MUL_P1;
      tpp_pkg::S_P2:      cmd_o.op = tpp_pkg::OP_MUL_P2;
      tpp_pkg::S_LIN:     cmd_o.op = tpp_pkg::OP_MUL_LIN;
      tpp_pkg::S_OUT: begin
        if (out_free) begin
          cmd_o.op    = tpp_pkg::OP_COMMIT;
          out_valid_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tpp_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == tpp_pkg::S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

FILE: rtl/tpp_checker.sv
// ----------------------------------------------------------------------------
// tpp_checker
// Port-level checks of the profile generator, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tpp_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic signed [31:0] angle_command_o,
  input logic [2:0]         profile_phase_o
);

  // Hold a stalled result
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(angle_command_o) && $stable(profile_phase_o), "stalled result changed")

  // One tick in flight: input closes after a transfer
  `ASSERT_NEXT(a_one_tick, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o, "input open during a tick")

  // A new result always returns the block to idle
  `ASSERT_AT(a_done_idle, clk_i, rst_ni, $rose(out_valid_o) |-> in_ready_o, "result without return to idle")

endmodule

bind trapezoidal_position_profile tpp_checker u_checker (.*);

FILE: tb/tb_trapezoidal_position_profile.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_trapezoidal_position_profile
// Drives enable/position ticks with random gaps and stalls, mirrors the
// profile planner and phase walker in a scoreboard, and checks every result.
// ----------------------------------------------------------------------------
import tpp_pkg::*;

typedef struct {
  int     cmd;
  phase_e ph;
} profile_result_t;

class profile_scoreboard;
  // configuration copy
  bit [31:0] tgt_angle, tgt_vel, tgt_acc, vel_lim, acc_lim;
  bit [30:0] ang_lim;
  // profile state
  phase_e    ph;
  bit        en_prev;
  int        start_pos, origin, dir;
  bit [31:0] cap_angle, cap_vel, cap_acc;
  bit [31:0] phase_time, ramp_time, cruise_time, peak_vel, applied_acc;
  profile_result_t expected_q[$];
  int errors;

  function new();
    tgt_angle = 0; tgt_vel = ONE_Q; tgt_acc = ONE_Q;
    ang_lim = ANGLE_LIMIT_RST; vel_lim = VEL_LIMIT_RST; acc_lim = ACC_LIMIT_RST;
    ph = PH_WAIT; en_prev = 0; start_pos = 0; origin = 0; dir = 0;
    cap_angle = 0; cap_vel = 0; cap_acc = 0;
    phase_time = 0; ramp_time = 0; cruise_time = 0; peak_vel = 0; applied_acc = 0;
    errors = 0;
  endfunction

  task report(string msg);
    $display("%0t mismatch: %s", $realtime, msg);
    errors++;
  endtask

  function void write_reg(cfg_idx_e idx, bit [31:0] val);
    case (idx)
      CFG_TARGET_ANGLE:    tgt_angle = val;
      CFG_TARGET_VELOCITY: tgt_vel   = val;
      CFG_TARGET_ACCEL:    tgt_acc   = val;
      CFG_ANGLE_LIMIT:     ang_lim   = val[30:0];
      CFG_VELOCITY_LIMIT:  vel_lim   = val;
      CFG_ACCEL_LIMIT:     acc_lim   = val;
      default: ;
    endcase
  endfunction

  function bit [31:0] sat_u32(bit [63:0] v);
    return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  function int sat_s32(longint v);
    if (v > longint'(32'sh7FFF_FFFF)) return 32'sh7FFF_FFFF;
    if (v < -longint'(64'sh8000_0000)) return 32'sh8000_0000;
    return int'(v);
  endfunction

  // fixed-point product, capped
  function bit [63:0] fx_mul(bit [63:0] x, bit [63:0] y);
    bit [127:0] p;
    p = ({64'd0, x} * {64'd0, y}) >> FRAC_BITS;
    return (p > {64'd0, PROD_CAP}) ? PROD_CAP : p[63:0];
  endfunction

  function bit [63:0] int_sqrt(bit [63:0] x);
    bit [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function void plan_move();
    longint    lim, fin, diff;
    bit [63:0] v, a, d, vv, q, r;
    lim = longint'(ang_lim);
    fin = longint'($signed(cap_angle));
    if (fin > lim) fin = lim;
    if (fin < -lim) fin = -lim;
    v = cap_vel;
    if (v > vel_lim) v = vel_lim;
    if (v < ONE_Q) v = ONE_Q;
    a = cap_acc;
    if (a > acc_lim) a = acc_lim;
    if (a < MIN_ACCEL_Q) a = MIN_ACCEL_Q;
    diff = fin - longint'(start_pos);
    dir = (diff > 0) ? 1 : ((diff < 0) ? -1 : 0);
    d = (diff < 0) ? -diff : diff;
    vv = v * v;
    q = vv / a;
    r = vv % a;
    applied_acc = a[31:0];
    // triangle when the move is too short to reach cruise speed
    if (d < q || (d == q && r != 0)) begin
      ramp_time   = sat_u32(int_sqrt(((d << FRAC_BITS) / a) << FRAC_BITS));
      cruise_time = 0;
      peak_vel    = sat_u32(fx_mul(ramp_time, a));
    end else begin
      ramp_time   = sat_u32((v << FRAC_BITS) / a);
      cruise_time = sat_u32(((d - q) << FRAC_BITS) / v);
      peak_vel    = v[31:0];
    end
  endfunction

  function void step_phase(bit [31:0] dur, int cmd, phase_e nxt);
    if (phase_time >= dur) begin
      origin = cmd;
      ph = nxt;
      phase_time = 0;
    end else begin
      phase_time = sat_u32(64'(phase_time) + DT_Q);
    end
  endfunction

  // predict the result of one accepted tick
  function void note_tick(bit en, int pos);
    longint para, lin;
    phase_e cur;
    int     cmd;
    para = longint'(fx_mul(fx_mul(phase_time, phase_time), applied_acc) >> 1);
    lin  = longint'(fx_mul(peak_vel, phase_time));
    if (en && !en_prev) begin
      start_pos = pos;
      cap_angle = tgt_angle; cap_vel = tgt_vel; cap_acc = tgt_acc;
      plan_move();
    end
    cur = en ? ph : PH_WAIT;
    case (cur)
      PH_ACCEL: begin
        cmd = sat_s32(longint'(origin) + dir * para);
        step_phase(ramp_time, cmd, PH_CRUISE);
      end
      PH_CRUISE: begin
        cmd = sat_s32(longint'(origin) + dir * lin);
        step_phase(cruise_time, cmd, PH_DECEL);
      end
      PH_DECEL: begin
        cmd = sat_s32(longint'(origin) + dir * (lin - para));
        step_phase(ramp_time, cmd, PH_HOLD);
      end
      PH_HOLD: begin
        cmd = origin;
        phase_time = 0;
      end
      default: begin
        cur = PH_WAIT;
        cmd = pos;
        origin = start_pos;
        phase_time = 0;
        ph = en ? PH_ACCEL : PH_WAIT;
      end
    endcase
    en_prev = en;
    expected_q.push_back('{cmd: cmd, ph: cur});
  endfunction

  task check_result(int cmd, bit [2:0] ph_bits);
    profile_result_t e;
    if (expected_q.size() == 0) begin
      report($sformatf("result %h/%0d with nothing outstanding", cmd, ph_bits));
    end else begin
      e = expected_q.pop_front();
      if (cmd !== e.cmd)
        report($sformatf("angle_command %h, predicted %h", cmd, e.cmd));
      if (ph_bits !== 3'(e.ph))
        report($sformatf("profile_phase %0d, predicted %0d", ph_bits, e.ph));
    end
  endtask
endclass

module tb_trapezoidal_position_profile;
  localparam int STALL_LIMIT = 3000;  // well above the slowest planning tick
  localparam int TICK_TARGET = 1550;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i, in_ready_o, move_enable_i;
  logic signed [31:0] measured_position_i;
  logic               out_valid_o, out_ready_i;
  logic signed [31:0] angle_command_o;
  logic [2:0]         profile_phase_o;
  logic               cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [31:0]        cfg_data_i;

  profile_scoreboard sb = new();
  int  ticks_sent = 0;
  int  quiet_cycles = 0;
  bit  no_idle = 0;  // set for stretches with back-to-back transfers

  trapezoidal_position_profile dut (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_o, .move_enable_i, .measured_position_i,
    .out_valid_o, .out_ready_i, .angle_command_o, .profile_phase_o,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  always #6 clk_i = ~clk_i;

  // Check each result transfer against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_result(angle_command_o, profile_phase_o);
  end

  // Watchdog: end the run if neither channel moves for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("FAIL trapezoidal_position_profile");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Receiver: stall a random number of cycles before taking each result.
  initial begin
    int stall;
    out_ready_i = 1'b0;
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 10);
      if (stall > 0) begin
        @(negedge clk_i);
        out_ready_i = 1'b0;
        repeat (stall - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      out_ready_i = 1'b1;
      @(posedge clk_i);
      while (!(out_valid_o && rst_ni)) @(posedge clk_i);
    end
  end

  // Offer one tick; hold valid high afterwards so a zero gap runs back to back.
  task automatic send_tick(bit en, logic [31:0] pos);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i = 1'b1;
    move_enable_i = en;
    measured_position_i = pos;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_tick(en, pos);
    ticks_sent++;
  endtask

  // Drop valid and let every outstanding result drain.
  task automatic drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = val;
    sb.write_reg(idx, val);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  function automatic logic [31:0] pick_limit(logic [31:0] typical);
    case ($urandom_range(0, 5))
      0: return 32'd0;           // inverted clamp, lower bound wins
      1: return 32'hFFFF_FFFF;
      2: return $urandom();
      default: return typical;
    endcase
  endfunction

  initial begin
    int        start, len;
    logic [31:0] ang;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    move_enable_i = 1'b0;
    measured_position_i = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_TARGET_ANGLE;
    cfg_data_i = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: pass-through extremes, then a zero-length move at reset settings.
    send_tick(0, 32'h7FFF_FFFF);
    send_tick(0, 32'h8000_0000);
    send_tick(1, 32'h0);
    send_tick(1, 32'h0);
    send_tick(1, 32'h0);
    send_tick(0, 32'hFFFF_FFFF);
    drain();

    // Most negative target, clamped by the angle limit, from the top of the range.
    write_reg(CFG_TARGET_ANGLE, 32'h8000_0000);
    send_tick(1, 32'h7FFF_FFFF);
    repeat (3) send_tick(1, $urandom());
    send_tick(0, 32'h0);
    drain();

    // Inverted limits and the widest move: saturating products and command.
    write_reg(CFG_VELOCITY_LIMIT, 32'h0);
    write_reg(CFG_ACCEL_LIMIT, 32'h0);
    write_reg(CFG_ANGLE_LIMIT, 32'h7FFF_FFFF);
    write_reg(CFG_TARGET_ANGLE, 32'h7FFF_FFFF);
    write_reg(CFG_TARGET_VELOCITY, 32'hFFFF_FFFF);
    write_reg(CFG_TARGET_ACCEL, 32'h0);
    send_tick(1, 32'h8000_0000);
    repeat (3) send_tick(1, 32'h0);
    send_tick(0, 32'h8000_0000);
    drain();
    write_reg(CFG_VELOCITY_LIMIT, 32'hFFFF_FFFF);
    write_reg(CFG_ACCEL_LIMIT, 32'hFFFF_FFFF);
    write_reg(CFG_TARGET_ACCEL, 32'hFFFF_FFFF);
    send_tick(1, 32'h7FFF_FFFF);
    repeat (4) send_tick(1, 32'h0);
    send_tick(0, 32'h0);

    // Random moves: short plans so that every phase is walked, plus noise.
    while (ticks_sent < TICK_TARGET) begin
      drain();
      no_idle = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 7) == 0) begin
        write_reg(CFG_ANGLE_LIMIT, pick_limit(ANGLE_LIMIT_RST));
        write_reg(CFG_VELOCITY_LIMIT, pick_limit(VEL_LIMIT_RST));
        write_reg(CFG_ACCEL_LIMIT, pick_limit(ACC_LIMIT_RST));
      end else begin
        write_reg(CFG_ANGLE_LIMIT, ANGLE_LIMIT_RST);
        write_reg(CFG_VELOCITY_LIMIT, VEL_LIMIT_RST);
        write_reg(CFG_ACCEL_LIMIT, ACC_LIMIT_RST);
      end
      start = ($urandom_range(0, 9) == 0) ? int'($urandom())
                                           : $urandom_range(0, 200 << 16) - (100 << 16);
      case ($urandom_range(0, 9))
        0: ang = start;                        // zero-length move
        1: ang = $urandom();
        default: ang = start + $urandom_range(0, 2 << 16) - (1 << 16);
      endcase
      write_reg(CFG_TARGET_ANGLE, ang);
      write_reg(CFG_TARGET_VELOCITY, ($urandom_range(1, 40) << 16) + $urandom_range(0, 65535));
      write_reg(CFG_TARGET_ACCEL, $urandom_range(200, 3000) << 16);
      repeat ($urandom_range(1, 3)) send_tick(0, $urandom());
      send_tick(1, start);
      len = $urandom_range(10, 120);
      repeat (len) begin
        // occasionally break the move with a low tick
        send_tick($urandom_range(0, 19) != 0, $urandom());
      end
      send_tick(0, $urandom());
    end

    drain();
    if (sb.errors == 0) begin
      $display("PASS trapezoidal_position_profile");
    end else begin
      $display("FAIL trapezoidal_position_profile");
    end
    $finish;
  end
endmodule
